FILE: hdl/pccs_pkg.sv
`timescale 1ns / 1ps

package pccs_pkg;

  // fixed field widths
  localparam int unsigned NOTE_W     = 15;
  localparam int unsigned TARGET_W   = 7;
  localparam int unsigned STRENGTH_W = 17;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CORR_W     = 16;

  // number format of the curve store
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned DIFF_W     =
      ((TARGET_W + FRAC_BITS) > NOTE_W ? (TARGET_W + FRAC_BITS) : NOTE_W) + 1;
  localparam int unsigned STORE_W    = DIFF_W + GUARD_BITS;

  localparam logic [STRENGTH_W-1:0] ONE_Q16 = STRENGTH_W'(65536);

  localparam int unsigned MAX_FRAMES_DEF = 64;
  localparam int unsigned FIFO_DEPTH     = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = STRENGTH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_NOTE = 2'd0,
    REG_STRENGTH    = 2'd1,
    REG_SMOOTH_EN   = 2'd2,
    REG_SMOOTH_COEF = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TARGET_W-1:0]   target_note;
    logic [STRENGTH_W-1:0] strength;     // already clamped to one
    logic                  smooth_enable;
    logic [COEF_W-1:0]     smooth_coef;
  } cfg_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note_value;
    logic              last_frame;
  } in_word_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correction;
    logic                     overflow;
    logic                     last_out;
  } out_word_t;

  // word passed from front to back through the command queue
  typedef struct packed {
    logic                      wr;       // store value at the frame address
    logic                      first;    // value is the first voiced correction
    logic                      fin;      // run ends, start the passes
    logic                      voiced;
    logic                      dropped;
    logic signed [STORE_W-1:0] value;
  } cmd_t;

endpackage

FILE: hdl/pitch_correction_curve_smoother.sv
`timescale 1ns / 1ps

// Pitch correction curve smoother.
// Input channel (push/full): one word per analysis frame, note_value in
// unsigned Q7.8 MIDI notes (zero is unvoiced) and last_frame on the final
// frame of a contour. Output channel (empty/pop): one correction word per
// stored frame, signed Q7.8 semitones, with overflow set when frames were
// dropped and last_out on the final word of the run.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 target_note, 1 strength, 2 smooth_enable, 3 smooth_coef); write only
// while no run is in flight.
// Frames are taken one per cycle into a 4-word command queue while it is
// not full; the idle back end pops a word and stores its frame. On the
// last frame the back end runs two smoothing passes over the n stored
// frames (when enabled and a frame was voiced), forward then backward,
// then the scaling pass, which reads, scales and outputs each word. Each
// filter step multiplies, then adds back, per frame.
// Frames of the next contour are taken while the back end is busy, until
// the queue fills. A stalled receiver holds the scaling pass, nothing lost.
// Reset empties queue and output and restores register defaults; the
// curve store itself is not cleared.
module pitch_correction_curve_smoother import pccs_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_word_i,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             out_word_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);

  logic [TARGET_W-1:0]   target_q;
  logic [STRENGTH_W-1:0] strength_q;
  logic                  smooth_en_q;
  logic [COEF_W-1:0]     coef_q;
  cfg_t                  cfg;

  logic             accept;
  logic             f_push;
  cmd_t             f_cmd;
  logic [IDX_W-1:0] f_addr, f_fvi;
  logic             q_empty, q_pop;
  cmd_t             q_cmd;
  logic [IDX_W-1:0] q_addr, q_fvi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_W'(60);
      strength_q  <= ONE_Q16;
      smooth_en_q <= 1'b0;
      coef_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_TARGET_NOTE: target_q    <= cfg_data_i[TARGET_W-1:0];
        REG_STRENGTH:    strength_q  <= cfg_data_i[STRENGTH_W-1:0];
        REG_SMOOTH_EN:   smooth_en_q <= cfg_data_i[0];
        REG_SMOOTH_COEF: coef_q      <= cfg_data_i[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.target_note   = target_q;
    cfg.strength      = (strength_q > ONE_Q16) ? ONE_Q16 : strength_q;
    cfg.smooth_enable = smooth_en_q;
    cfg.smooth_coef   = coef_q;
  end

  assign accept = push && !full;

  pccs_front #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .push_o    (f_push),
    .cmd_o     (f_cmd),
    .addr_o    (f_addr),
    .fvi_o     (f_fvi)
  );

  pccs_cmd_fifo #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .cmd_i   (f_cmd),
    .addr_i  (f_addr),
    .fvi_i   (f_fvi),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd),
    .addr_o  (q_addr),
    .fvi_o   (q_fvi)
  );

  pccs_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fifo_empty_i (q_empty),
    .fifo_pop_o   (q_pop),
    .cmd_i        (q_cmd),
    .cmd_addr_i   (q_addr),
    .cmd_fvi_i    (q_fvi),
    .out_pop_i    (pop),
    .out_empty_o  (empty),
    .out_word_o   (out_word_o)
  );

endmodule

FILE: hdl/pccs_ram.sv
`timescale 1ns / 1ps

module pccs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pccs_front.sv
`timescale 1ns / 1ps

module pccs_front import pccs_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          accept_i,
  input  in_word_t                      in_word_i,
  output logic                          push_o,
  output cmd_t                          cmd_o,
  output logic [$clog2(MAX_FRAMES)-1:0] addr_o,
  output logic [$clog2(MAX_FRAMES)-1:0] fvi_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [STORE_W-1:0] held_q, held_d;
  logic                      voiced_q, voiced_d;
  logic [IDX_W-1:0]          fvi_q, fvi_d;
  logic                      dropped_q, dropped_d;

  logic [TARGET_W+FRAC_BITS-1:0] tq;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [STORE_W-1:0]     corr;
  logic                          room;
  logic                          voiced_now;
  logic                          first_now;

  always_comb begin
    tq         = {cfg_i.target_note, {FRAC_BITS{1'b0}}};
    diff       = $signed(DIFF_W'(tq)) - $signed(DIFF_W'(in_word_i.note_value));
    corr       = {diff, {GUARD_BITS{1'b0}}};
    room       = (count_q != CNT_W'(MAX_FRAMES));
    voiced_now = (in_word_i.note_value != '0);
    first_now  = room && voiced_now && !voiced_q;

    cmd_o.wr      = room;
    cmd_o.first   = first_now;
    cmd_o.fin     = in_word_i.last_frame;
    cmd_o.voiced  = voiced_q || (room && voiced_now);
    cmd_o.dropped = dropped_q || !room;
    cmd_o.value   = voiced_now ? corr : held_q;
    addr_o        = count_q[IDX_W-1:0];
    fvi_o         = first_now ? count_q[IDX_W-1:0] : fvi_q;

    // a dropped frame that does not end the run leaves nothing for the back
    push_o = accept_i && (room || in_word_i.last_frame);

    count_d   = count_q;
    held_d    = held_q;
    voiced_d  = voiced_q;
    fvi_d     = fvi_q;
    dropped_d = dropped_q;
    if (accept_i) begin
      if (in_word_i.last_frame) begin
        count_d   = '0;
        held_d    = '0;
        voiced_d  = 1'b0;
        fvi_d     = '0;
        dropped_d = 1'b0;
      end else if (room) begin
        count_d = count_q + CNT_W'(1);
        if (voiced_now) begin
          held_d = corr;
        end
        if (first_now) begin
          voiced_d = 1'b1;
          fvi_d    = count_q[IDX_W-1:0];
        end
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      held_q    <= '0;
      voiced_q  <= 1'b0;
      fvi_q     <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      held_q    <= held_d;
      voiced_q  <= voiced_d;
      fvi_q     <= fvi_d;
      dropped_q <= dropped_d;
    end
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_FRAMES))
    else $error("frame count beyond store size");
`endif

endmodule

FILE: hdl/pccs_cmd_fifo.sv
`timescale 1ns / 1ps

module pccs_cmd_fifo import pccs_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  cmd_t                          cmd_i,
  input  logic [$clog2(MAX_FRAMES)-1:0] addr_i,
  input  logic [$clog2(MAX_FRAMES)-1:0] fvi_i,
  output logic                          full_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output cmd_t                          cmd_o,
  output logic [$clog2(MAX_FRAMES)-1:0] addr_o,
  output logic [$clog2(MAX_FRAMES)-1:0] fvi_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             cmd_q  [FIFO_DEPTH];
  logic [IDX_W-1:0] addr_q [FIFO_DEPTH];
  logic [IDX_W-1:0] fvi_q  [FIFO_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign cmd_o  = cmd_q[rd_ptr_q];
  assign addr_o = addr_q[rd_ptr_q];
  assign fvi_o  = fvi_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q]  <= cmd_i;
      addr_q[wr_ptr_q] <= addr_i;
      fvi_q[wr_ptr_q]  <= fvi_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command word pushed into a full queue");
`endif

endmodule

FILE: hdl/pccs_back.sv
`timescale 1ns / 1ps

module pccs_back import pccs_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          fifo_empty_i,
  output logic                          fifo_pop_o,
  input  cmd_t                          cmd_i,
  input  logic [$clog2(MAX_FRAMES)-1:0] cmd_addr_i,
  input  logic [$clog2(MAX_FRAMES)-1:0] cmd_fvi_i,
  input  logic                          out_pop_i,
  output logic                          out_empty_o,
  output out_word_t                     out_word_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned FPW   = STORE_W + COEF_W + 2;
  localparam int unsigned SPW   = STORE_W + STRENGTH_W + 1;
  localparam int unsigned SSH   = 16 + GUARD_BITS;

  localparam logic signed [FPW-1:0] FRND   = FPW'(1) << 15;
  localparam logic signed [SPW-1:0] SRND   = SPW'(1) << (SSH - 1);
  localparam logic signed [SPW-1:0] SAT_HI = SPW'((1 << (CORR_W - 1)) - 1);
  localparam logic signed [SPW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FRD  = 7'b0000010,
    ST_FMUL = 7'b0000100,
    ST_FACC = 7'b0001000,
    ST_SRD  = 7'b0010000,
    ST_SMUL = 7'b0100000,
    ST_SOUT = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [IDX_W-1:0]          last_idx_q, last_idx_d;
  logic [IDX_W-1:0]          fvi_q, fvi_d;
  logic signed [STORE_W-1:0] first_val_q, first_val_d;
  logic                      voiced_q, voiced_d;
  logic                      dropped_q, dropped_d;
  logic                      smooth_q, smooth_d;
  logic                      bwd_q, bwd_d;
  logic                      init_q, init_d;
  logic signed [STORE_W-1:0] y_q, y_d;
  logic signed [STORE_W-1:0] x_q;
  logic signed [FPW-1:0]     fprod_q;
  logic signed [SPW-1:0]     sprod_q;
  out_word_t                 out_q;
  logic                      out_valid_q;

  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_waddr, ram_raddr;
  logic signed [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0]        ram_rdata;

  logic                      use_fill;
  logic signed [STORE_W-1:0] x_mux;
  logic signed [STORE_W:0]   d;
  logic signed [COEF_W:0]    a_s;
  logic signed [FPW-1:0]     fprod_d;
  logic signed [FPW-1:0]     fsum, fstep;
  logic signed [STORE_W:0]   y_wide;
  logic signed [STORE_W-1:0] y_new;
  logic signed [STRENGTH_W:0] s_s;
  logic signed [SPW-1:0]     sprod_d;
  logic signed [SPW-1:0]     ssum, sval;
  logic signed [CORR_W-1:0]  corr_sat;
  logic                      at_end;
  logic                      out_load;

  pccs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    // frames ahead of the first voiced one read as its correction
    use_fill = (idx_q < fvi_q) && ((state_q == ST_FMUL) ? !bwd_q : !smooth_q);
    x_mux    = use_fill ? first_val_q : $signed(ram_rdata);

    // y' = x + a*(y - x)/2^16, rounded half up
    d       = init_q ? '0 : ($signed({y_q[STORE_W-1], y_q}) - $signed({x_mux[STORE_W-1], x_mux}));
    a_s     = $signed({1'b0, cfg_i.smooth_coef});
    fprod_d = d * a_s;
    fsum    = fprod_q + FRND;
    fstep   = fsum >>> 16;
    y_wide  = $signed({x_q[STORE_W-1], x_q}) + fstep[STORE_W:0];
    y_new   = y_wide[STORE_W-1:0];

    s_s     = $signed({1'b0, cfg_i.strength});
    sprod_d = x_mux * s_s;
    ssum    = sprod_q + SRND;
    sval    = ssum >>> SSH;
    if (sval > SAT_HI) begin
      corr_sat = SAT_HI[CORR_W-1:0];
    end else if (sval < SAT_LO) begin
      corr_sat = SAT_LO[CORR_W-1:0];
    end else begin
      corr_sat = sval[CORR_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    last_idx_d  = last_idx_q;
    fvi_d       = fvi_q;
    first_val_d = first_val_q;
    voiced_d    = voiced_q;
    dropped_d   = dropped_q;
    smooth_d    = smooth_q;
    bwd_d       = bwd_q;
    init_d      = init_q;
    y_d         = y_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = y_new;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    fifo_pop_o  = 1'b0;
    out_load    = 1'b0;
    at_end      = bwd_q ? (idx_q == '0) : (idx_q == last_idx_q);

    case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          if (cmd_i.wr) begin
            ram_we    = 1'b1;
            ram_waddr = cmd_addr_i;
            ram_wdata = cmd_i.value;
          end
          if (cmd_i.first) begin
            first_val_d = cmd_i.value;
          end
          if (cmd_i.fin) begin
            last_idx_d = cmd_i.wr ? cmd_addr_i : IDX_W'(MAX_FRAMES - 1);
            fvi_d      = cmd_fvi_i;
            voiced_d   = cmd_i.voiced;
            dropped_d  = cmd_i.dropped;
            smooth_d   = cmd_i.voiced && cfg_i.smooth_enable;
            idx_d      = '0;
            bwd_d      = 1'b0;
            state_d    = (cmd_i.voiced && cfg_i.smooth_enable) ? ST_FRD : ST_SRD;
          end
        end
      end
      ST_FRD: begin
        ram_re  = 1'b1;
        init_d  = 1'b1;
        state_d = ST_FMUL;
      end
      ST_FMUL: begin
        state_d = ST_FACC;
      end
      ST_FACC: begin
        ram_we = 1'b1;
        y_d    = y_new;
        init_d = 1'b0;
        if (at_end) begin
          if (!bwd_q) begin
            bwd_d   = 1'b1;
            idx_d   = last_idx_q;
            state_d = ST_FRD;
          end else begin
            idx_d   = '0;
            state_d = ST_SRD;
          end
        end else begin
          // fetch the next sample while this one is written back
          idx_d     = bwd_q ? (idx_q - IDX_W'(1)) : (idx_q + IDX_W'(1));
          ram_re    = 1'b1;
          ram_raddr = idx_d;
          state_d   = ST_FMUL;
        end
      end
      ST_SRD: begin
        ram_re  = 1'b1;
        state_d = ST_SMUL;
      end
      ST_SMUL: begin
        state_d = ST_SOUT;
      end
      ST_SOUT: begin
        if (!out_valid_q || out_pop_i) begin
          out_load = 1'b1;
          if (idx_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d     = idx_q + IDX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_d;
            state_d   = ST_SMUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FMUL) begin
      x_q     <= x_mux;
      fprod_q <= fprod_d;
    end
    if (state_q == ST_SMUL) begin
      sprod_q <= sprod_d;
    end
    if (out_load) begin
      out_q.correction <= voiced_q ? corr_sat : '0;
      out_q.overflow   <= dropped_q;
      out_q.last_out   <= (idx_q == last_idx_q);
    end
    first_val_q <= first_val_d;
    y_q         <= y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      last_idx_q  <= '0;
      fvi_q       <= '0;
      voiced_q    <= 1'b0;
      dropped_q   <= 1'b0;
      smooth_q    <= 1'b0;
      bwd_q       <= 1'b0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
      fvi_q      <= fvi_d;
      voiced_q   <= voiced_d;
      dropped_q  <= dropped_d;
      smooth_q   <= smooth_d;
      bwd_q      <= bwd_d;
      init_q     <= init_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_empty_o = !out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (idx_q <= last_idx_q))
    else $error("pass index beyond the stored frames");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("store read and written at the same entry");

  a_acc_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FACC) |-> ($past(state_q) == ST_FMUL))
    else $error("filter accumulate without a product");
`endif

endmodule

FILE: sim/pitch_correction_curve_smoother_tb.sv
`timescale 1ns / 1ps

module pitch_correction_curve_smoother_tb;
  import pccs_pkg::*;

  localparam int unsigned DEPTH         = MAX_FRAMES_DEF;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_FRAMES = 310;
  localparam int unsigned MAX_STRENGTH  = (1 << STRENGTH_W) - 1;
  localparam int unsigned MAX_COEF      = (1 << COEF_W) - 1;
  localparam int unsigned MAX_TARGET    = (1 << TARGET_W) - 1;
  localparam logic [NOTE_W-1:0] NOTE_MAX = '1;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push       = 1'b0;
  logic                  full;
  in_word_t              in_word_i  = '0;
  logic                  empty;
  logic                  pop        = 1'b0;
  out_word_t             out_word_o;

  pitch_correction_curve_smoother i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  // register copies
  logic [TARGET_W-1:0]   target_q   = TARGET_W'(60);
  logic [STRENGTH_W-1:0] strength_q = ONE_Q16;
  logic                  smooth_on_q = 1'b0;
  logic [COEF_W-1:0]     coef_q     = '0;

  // curve state
  longint      curve [DEPTH];
  int unsigned frame_cnt    = 0;
  longint      held_corr    = 0;
  bit          voiced_seen  = 1'b0;
  int unsigned first_voiced = 0;
  bit          dropped      = 1'b0;

  in_word_t    frame_q[$];
  out_word_t   corr_expect_q[$];

  bit          no_gaps = 1'b0;
  int unsigned push_wait = 0;
  int unsigned pop_wait  = 0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned frames_taken = 0;
  int unsigned contours_done = 0;
  int unsigned cfg_phases = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // round half up, floor semantics for negative values
  function automatic longint round_shift(longint v, int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint pole(longint y, longint x);
    return round_shift(longint'(coef_q) * y + (longint'(65536) - longint'(coef_q)) * x, 16);
  endfunction

  function automatic void track_frame(in_word_t w);
    int unsigned n;
    longint      y;
    longint      v;
    longint      sc;
    out_word_t   r;
    if (frame_cnt < DEPTH) begin
      if (w.note_value != 0) begin
        held_corr = ((longint'(target_q) <<< FRAC_BITS) - longint'(w.note_value)) <<< GUARD_BITS;
        if (!voiced_seen) begin
          voiced_seen = 1'b1;
          first_voiced = frame_cnt;
        end
      end
      curve[frame_cnt] = held_corr;
      frame_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (!w.last_frame) return;

    n = frame_cnt;
    if (voiced_seen) begin
      // leading unvoiced frames take the first voiced correction
      for (int unsigned i = 0; i < first_voiced; i++) curve[i] = curve[first_voiced];
      if (smooth_on_q) begin
        y = curve[0];
        for (int unsigned i = 0; i < n; i++) begin
          y = pole(y, curve[i]);
          curve[i] = y;
        end
        y = curve[n - 1];
        for (int i = int'(n) - 1; i >= 0; i--) begin
          y = pole(y, curve[i]);
          curve[i] = y;
        end
      end
    end

    sc = (strength_q > ONE_Q16) ? longint'(ONE_Q16) : longint'(strength_q);
    for (int unsigned i = 0; i < n; i++) begin
      v = 0;
      if (voiced_seen) begin
        v = round_shift(curve[i] * sc, 16 + GUARD_BITS);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      r.correction = v[CORR_W-1:0];
      r.overflow   = dropped;
      r.last_out   = (i == n - 1);
      corr_expect_q.insert(corr_expect_q.size(), r);
    end

    frame_cnt    = 0;
    held_corr    = 0;
    voiced_seen  = 1'b0;
    first_voiced = 0;
    dropped      = 1'b0;
    contours_done++;
  endfunction

  // input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        track_frame(in_word_i);
        frames_taken++;
      end
      if (!push || !full) begin
        if (push_wait != 0) begin
          push <= 1'b0;
          push_wait--;
        end else if (frame_q.size() != 0) begin
          push <= 1'b1;
          in_word_i <= frame_q.pop_front();
          push_wait = no_gaps ? 0 : $urandom_range(0, 3);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        words_checked++;
        if (corr_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: corr %0d ovf %0b last %0b", out_word_o.correction,
                     out_word_o.overflow, out_word_o.last_out);
        end else begin
          want = corr_expect_q.pop_front();
          if (out_word_o.correction !== want.correction || out_word_o.overflow !== want.overflow
              || out_word_o.last_out !== want.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected corr %0d ovf %0b last %0b, got corr %0d ovf %0b last %0b",
                       words_checked, want.correction, want.overflow, want.last_out,
                       out_word_o.correction, out_word_o.overflow, out_word_o.last_out);
          end
        end
        pop_wait = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (pop_wait != 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    case (idx)
      REG_TARGET_NOTE: target_q    = TARGET_W'(data);
      REG_STRENGTH:    strength_q  = STRENGTH_W'(data);
      REG_SMOOTH_EN:   smooth_on_q = data[0];
      REG_SMOOTH_COEF: coef_q      = COEF_W'(data);
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned tgt, int unsigned str, int unsigned en,
                            int unsigned coef);
    write_reg(REG_TARGET_NOTE, tgt);
    write_reg(REG_STRENGTH, str);
    write_reg(REG_SMOOTH_EN, en);
    write_reg(REG_SMOOTH_COEF, coef);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    cfg_phases++;
  endtask

  task automatic wait_idle(int unsigned settle);
    do @(negedge clk_i);
    while (frame_q.size() != 0 || push || corr_expect_q.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  function automatic logic [NOTE_W-1:0] pick_note();
    int n;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(1, 32767);
      1: n = $urandom_range(0, 1) ? 1 : 32767;
      default: n = (int'(target_q) << FRAC_BITS) + $urandom_range(0, 2048) - 1024;
    endcase
    if (n < 1) n = 1;
    if (n > 32767) n = 32767;
    return NOTE_W'(n);
  endfunction

  function automatic void add_word(logic [NOTE_W-1:0] note, bit last);
    in_word_t w;
    w.note_value = note;
    w.last_frame = last;
    frame_q.insert(frame_q.size(), w);
  endfunction

  function automatic void add_contour(int unsigned len, int unsigned unvoiced_pct);
    for (int unsigned i = 0; i < len; i++)
      add_word(($urandom_range(0, 99) < unvoiced_pct) ? '0 : pick_note(), i == len - 1);
  endfunction

  initial begin
    int unsigned budget;
    int unsigned phase_frames;
    int unsigned len;
    int unsigned pick;
    int unsigned tgt;
    int unsigned str;
    int unsigned coef;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: unity strength, smoothing off
    add_word(NOTE_W'(1), 1'b1);
    add_word(NOTE_MAX, 1'b1);
    // leading unvoiced, exact hit on the target, held gap, trailing unvoiced
    add_word('0, 1'b0);
    add_word('0, 1'b0);
    add_word(NOTE_W'(60 << FRAC_BITS), 1'b0);
    add_word('0, 1'b0);
    add_word(NOTE_W'((61 << FRAC_BITS) + 128), 1'b0);
    add_word('0, 1'b1);
    // nothing voiced gives zeros
    add_word('0, 1'b0);
    add_word('0, 1'b0);
    add_word('0, 1'b1);
    add_word('0, 1'b1);
    wait_idle(8);

    set_config(MAX_TARGET, ONE_Q16, 1, MAX_COEF);
    add_word('0, 1'b0);
    add_word(NOTE_MAX, 1'b0);
    add_word(NOTE_W'(1), 1'b0);
    add_word('0, 1'b1);
    wait_idle(8);

    set_config(0, 0, 1, 0);
    add_word(NOTE_W'(1), 1'b0);
    add_word(NOTE_MAX, 1'b1);
    wait_idle(8);

    // strength above one, and a contour longer than the store with the mark dropped
    set_config(64, MAX_STRENGTH, 0, 0);
    add_contour(DEPTH + 2, 20);
    wait_idle(8);
    budget = frames_taken;

    while (budget < RANDOM_FRAMES) begin
      tgt = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? MAX_TARGET : 0)
                                         : $urandom_range(0, MAX_TARGET);
      case ($urandom_range(0, 4))
        0: str = ONE_Q16;
        1: str = $urandom_range(0, 1) ? MAX_STRENGTH : 0;
        2: str = $urandom_range(65537, MAX_STRENGTH);
        default: str = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 3))
        0: coef = 0;
        1: coef = MAX_COEF;
        default: coef = $urandom_range(0, MAX_COEF);
      endcase
      set_config(tgt, str, $urandom_range(0, 1), coef);
      no_gaps = ($urandom_range(0, 3) == 0);

      phase_frames = 0;
      while (phase_frames < 40) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) len = $urandom_range(1, 12);
        else if (pick < 9) len = $urandom_range(13, 40);
        else len = $urandom_range(DEPTH - 4, DEPTH + 4);
        add_contour(len, ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 50));
        phase_frames += len;
      end
      budget += phase_frames;
      wait_idle(8);
    end

    no_gaps = 1'b0;
    wait_idle(300);
    $display("%0d frames in %0d contours, %0d correction words checked",
             frames_taken, contours_done, words_checked);
    $display("%0d register settings, with smoothing, clamped strength and store overflow",
             cfg_phases);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pccs_pkg.sv
hdl/pccs_ram.sv
hdl/pccs_front.sv
hdl/pccs_cmd_fifo.sv
hdl/pccs_back.sv
hdl/pitch_correction_curve_smoother.sv
sim/pitch_correction_curve_smoother_tb.sv
